@@ src/rmot_pkg.sv @@
// Shared types and constants of the root move ordering table.
// Used by rmot_store, root_move_ordering_table, rmot_checker and the testbench top; depends on nothing else.
package rmot_pkg;

    localparam int MAX_MOVES_DEF = 256;

    localparam logic [2:0] MODE_CLEAR      = 3'd0;
    localparam logic [2:0] MODE_APPEND     = 3'd1;
    localparam logic [2:0] MODE_CLEAR_FLAG = 3'd2;
    localparam logic [2:0] MODE_SELECT     = 3'd3;
    localparam logic [2:0] MODE_UPDATE     = 3'd4;
    localparam logic [2:0] MODE_READ       = 3'd5;

    localparam logic [1:0] FLAG_NONE  = 2'd0;
    localparam logic [1:0] FLAG_ALPHA = 2'd1;
    localparam logic [1:0] FLAG_BETA  = 2'd2;

    typedef struct packed {
        logic [2:0]         mode;
        logic [15:0]        move_code;
        logic signed [15:0] alpha_bound;
        logic signed [15:0] beta_bound;
        logic [7:0]         search_depth;
        logic signed [15:0] new_score;
        logic [1:0]         new_flag;
        logic [7:0]         entry_index;
    } cmd_t;

    typedef struct packed {
        logic               found;
        logic [7:0]         position;
        logic [15:0]        entry_move;
        logic signed [15:0] entry_score;
        logic [1:0]         entry_flag;
        logic [7:0]         entry_depth;
        logic               at_front;
        logic [8:0]         entry_count;
        logic               full_error;
    } rsp_t;

    // One table entry without its flag; flags live in their own array so
    // that clearing them needs no read.
    typedef struct packed {
        logic [15:0]        move;
        logic signed [15:0] score;
        logic [7:0]         depth;
    } entry_t;

    typedef struct packed {
        logic entry_we;
        logic flag_we;
    } store_we_t;

endpackage

@@ src/root_move_ordering_table.sv @@
// Root move ordering table: command channel cmd, result channel rsp.
// Uses rmot_pkg and rmot_store.
//
// Every accepted cmd item gives exactly one rsp item. Both channels use
// valid/stall; an item moves on a rising edge where valid is high and stall
// is low. The block takes one command at a time: cmd_stall is high from the
// edge that accepts a command until its result has been placed in the
// output register. A result waiting in that register does not stop the next
// command from being accepted; only the following hand-over to the output
// waits while rsp_stall is high.
// Steps from accept to result, n being the number of stored moves: execute
// for every mode, then a read state for an in-range read, n flag writes for
// clear flags (one flag write a cycle), a scan for select (one entry compare
// a cycle through the read port), and for update with a current entry a
// load, one compare per place moved forward and a final compare or write;
// then done. The single memory read port and the one compare per cycle set
// these steps. After reset the table is empty and the current position is
// zero; table contents need no clearing because only appended entries are
// read.
module root_move_ordering_table #(
    parameter int MAX_MOVES = rmot_pkg::MAX_MOVES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  rmot_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rmot_pkg::rsp_t rsp
);

    localparam int IDX_W = $clog2(MAX_MOVES);
    localparam int CNT_W = $clog2(MAX_MOVES + 1);
    localparam int EXT_W = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MOVES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_FLAGS,
        S_SCAN,
        S_UPD_LOAD,
        S_UPD_CMP,
        S_UPD_FIN,
        S_READ,
        S_DONE
    } state_t;

    state_t             state_reg;
    rmot_pkg::cmd_t     item_reg;
    rmot_pkg::rsp_t     res_reg;
    rmot_pkg::rsp_t     rsp_reg;
    logic               rsp_valid_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   cur_reg;
    logic [CNT_W-1:0]   ptr_reg;
    logic               pend_reg;
    logic [CNT_W-1:0]   pend_idx_reg;
    rmot_pkg::entry_t   carry_reg;
    logic [1:0]         carry_flag_reg;

    rmot_pkg::store_we_t we;
    logic [IDX_W-1:0]    wr_addr;
    rmot_pkg::entry_t    wr_entry;
    logic [1:0]          wr_flag;
    logic [IDX_W-1:0]    rd_addr;
    rmot_pkg::entry_t    rd_entry;
    logic [1:0]          rd_flag;

    logic [CNT_W-1:0] ptr_inc;
    logic [CNT_W-1:0] cur_dec;
    logic [CNT_W-1:0] cur_dec2;
    logic [EXT_W-1:0] index_ext;
    logic [EXT_W-1:0] count_ext;
    logic             read_in_range;
    logic             cur_valid;
    logic             scan_issue;
    logic             hit;
    logic             swap;
    logic             hand_over;
    rmot_pkg::rsp_t   exec_res;
    rmot_pkg::rsp_t   done_rsp;

    assign ptr_inc       = ptr_reg + CNT_ONE;
    assign cur_dec       = cur_reg - CNT_ONE;
    assign cur_dec2      = cur_reg - CNT_TWO;
    assign index_ext     = EXT_W'(item_reg.entry_index);
    assign count_ext     = EXT_W'(count_reg);
    assign read_in_range = index_ext < count_ext;
    assign cur_valid     = cur_reg < count_reg;
    assign scan_issue    = ptr_reg < count_reg;
    assign hand_over     = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    // Select test on the entry whose data sits in the read register.
    assign hit = (rd_entry.depth < item_reg.search_depth)
              || (rd_flag == rmot_pkg::FLAG_ALPHA && rd_entry.score < item_reg.beta_bound)
              || (rd_flag == rmot_pkg::FLAG_BETA && rd_entry.score > item_reg.alpha_bound);

    // The moving entry passes the one before it on equal depth and a
    // strictly larger score.
    assign swap = (rd_entry.depth == carry_reg.depth) && (carry_reg.score > rd_entry.score);

    // Result of the commands that finish in the execute cycle, and the final
    // result with the table status added.
    always_comb
    begin
        exec_res = '0;
        if (item_reg.mode == rmot_pkg::MODE_APPEND)
        begin
            if (count_reg < CNT_MAX)
            begin
                exec_res.found      = 1'b1;
                exec_res.position   = 8'(count_reg);
                exec_res.entry_move = item_reg.move_code;
            end
            else
            begin
                exec_res.full_error = 1'b1;
            end
        end
        if (item_reg.mode == rmot_pkg::MODE_READ && !read_in_range)
        begin
            exec_res.position = item_reg.entry_index;
        end
        done_rsp             = res_reg;
        done_rsp.at_front    = (cur_reg == '0);
        done_rsp.entry_count = 9'(count_reg);
    end

    always_comb
    begin
        we       = '0;
        wr_addr  = count_reg[IDX_W-1:0];
        wr_entry = carry_reg;
        wr_flag  = carry_flag_reg;
        rd_addr  = cur_reg[IDX_W-1:0];
        unique case (state_reg)
            S_EXEC:
            begin
                if (item_reg.mode == rmot_pkg::MODE_APPEND && count_reg < CNT_MAX)
                begin
                    we.entry_we    = 1'b1;
                    we.flag_we     = 1'b1;
                    wr_entry.move  = item_reg.move_code;
                    wr_entry.score = '0;
                    wr_entry.depth = '0;
                    wr_flag        = rmot_pkg::FLAG_NONE;
                end
                if (item_reg.mode == rmot_pkg::MODE_READ)
                begin
                    rd_addr = index_ext[IDX_W-1:0];
                end
            end
            S_FLAGS:
            begin
                we.flag_we = 1'b1;
                wr_addr    = ptr_reg[IDX_W-1:0];
                wr_flag    = rmot_pkg::FLAG_NONE;
            end
            S_SCAN:
            begin
                rd_addr = ptr_reg[IDX_W-1:0];
            end
            S_UPD_LOAD:
            begin
                rd_addr = cur_dec[IDX_W-1:0];
            end
            S_UPD_CMP:
            begin
                // Fetch the next neighbor in case this step swaps.
                rd_addr     = cur_dec2[IDX_W-1:0];
                we.entry_we = 1'b1;
                we.flag_we  = 1'b1;
                wr_addr     = cur_reg[IDX_W-1:0];
                if (swap)
                begin
                    wr_entry = rd_entry;
                    wr_flag  = rd_flag;
                end
            end
            S_UPD_FIN:
            begin
                we.entry_we = 1'b1;
                we.flag_we  = 1'b1;
                wr_addr     = cur_reg[IDX_W-1:0];
            end
            S_IDLE, S_READ, S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    rmot_store #(
        .DEPTH  (MAX_MOVES),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk      (clk),
        .we       (we),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .wr_flag  (wr_flag),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .rd_flag  (rd_flag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            cur_reg       <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (hand_over)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        item_reg  <= cmd;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_reg   <= exec_res;
                    state_reg <= S_DONE;
                    unique case (item_reg.mode)
                        rmot_pkg::MODE_CLEAR:
                        begin
                            count_reg <= '0;
                            cur_reg   <= '0;
                        end
                        rmot_pkg::MODE_APPEND:
                        begin
                            if (count_reg < CNT_MAX)
                            begin
                                count_reg <= count_reg + CNT_ONE;
                            end
                        end
                        rmot_pkg::MODE_CLEAR_FLAG:
                        begin
                            ptr_reg <= '0;
                            if (count_reg != '0)
                            begin
                                state_reg <= S_FLAGS;
                            end
                        end
                        rmot_pkg::MODE_SELECT:
                        begin
                            ptr_reg   <= '0;
                            pend_reg  <= 1'b0;
                            state_reg <= S_SCAN;
                        end
                        rmot_pkg::MODE_UPDATE:
                        begin
                            if (cur_valid)
                            begin
                                state_reg <= S_UPD_LOAD;
                            end
                        end
                        rmot_pkg::MODE_READ:
                        begin
                            if (read_in_range)
                            begin
                                state_reg <= S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_FLAGS:
                begin
                    ptr_reg <= ptr_inc;
                    if (ptr_inc == count_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_SCAN:
                begin
                    priority if (pend_reg && hit)
                    begin
                        cur_reg   <= pend_idx_reg;
                        res_reg   <= '{found: 1'b1, position: 8'(pend_idx_reg),
                                       entry_move: rd_entry.move,
                                       entry_score: rd_entry.score,
                                       entry_flag: rd_flag,
                                       entry_depth: rd_entry.depth, default: '0};
                        state_reg <= S_DONE;
                    end
                    else if (scan_issue)
                    begin
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= ptr_reg;
                        ptr_reg      <= ptr_inc;
                    end
                    else
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= S_DONE;
                    end
                end
                S_UPD_LOAD:
                begin
                    carry_reg      <= '{move: rd_entry.move, score: item_reg.new_score,
                                        depth: item_reg.search_depth};
                    carry_flag_reg <= item_reg.new_flag;
                    state_reg      <= (cur_reg == '0) ? S_UPD_FIN : S_UPD_CMP;
                end
                S_UPD_CMP:
                begin
                    if (swap)
                    begin
                        cur_reg <= cur_dec;
                        if (cur_dec == '0)
                        begin
                            state_reg <= S_UPD_FIN;
                        end
                    end
                    else
                    begin
                        res_reg   <= '{found: 1'b1, position: 8'(cur_reg),
                                       entry_move: carry_reg.move,
                                       entry_score: carry_reg.score,
                                       entry_flag: carry_flag_reg,
                                       entry_depth: carry_reg.depth, default: '0};
                        state_reg <= S_DONE;
                    end
                end
                S_UPD_FIN:
                begin
                    res_reg   <= '{found: 1'b1, position: 8'(cur_reg),
                                   entry_move: carry_reg.move,
                                   entry_score: carry_reg.score,
                                   entry_flag: carry_flag_reg,
                                   entry_depth: carry_reg.depth, default: '0};
                    state_reg <= S_DONE;
                end
                S_READ:
                begin
                    res_reg   <= '{found: 1'b1, position: item_reg.entry_index,
                                   entry_move: rd_entry.move,
                                   entry_score: rd_entry.score,
                                   entry_flag: rd_flag,
                                   entry_depth: rd_entry.depth, default: '0};
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (hand_over)
                    begin
                        rsp_reg   <= done_rsp;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("move count above table size");

    a_cur_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg == '0) || (cur_reg < count_reg))
        else $error("current position outside the table");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !(we.entry_we || we.flag_we))
        else $error("table written while no command runs");

    a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && cmd.mode == rmot_pkg::MODE_APPEND
            && count_reg < CNT_MAX)
        |=> ##1 (count_reg == CNT_W'($past(count_reg, 2) + CNT_ONE)))
        else $error("append did not grow the table by one");
`endif

endmodule

@@ src/rmot_store.sv @@
// Entry and flag arrays of the root move ordering table.
// One write port and one registered read port each; uses rmot_pkg.
module rmot_store #(
    parameter int DEPTH  = rmot_pkg::MAX_MOVES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  rmot_pkg::store_we_t we,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  rmot_pkg::entry_t    wr_entry,
    input  logic [1:0]          wr_flag,
    input  logic [ADDR_W-1:0]   rd_addr,
    output rmot_pkg::entry_t    rd_entry,
    output logic [1:0]          rd_flag
);

    rmot_pkg::entry_t entry_mem [DEPTH];
    logic [1:0]       flag_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we.entry_we)
        begin
            entry_mem[wr_addr] <= wr_entry;
        end
        rd_entry <= entry_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.flag_we)
        begin
            flag_mem[wr_addr] <= wr_flag;
        end
        rd_flag <= flag_mem[rd_addr];
    end

endmodule

@@ sim/rmot_checker.sv @@
// Checker for the root move ordering table: watches both channels, predicts
// each result from its own copy of the table and compares it field by field.
// Depends on rmot_pkg for the item types and command codes.
module rmot_checker #(
    parameter int MAX_MOVES = rmot_pkg::MAX_MOVES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  logic           cmd_stall,
    input  rmot_pkg::cmd_t cmd,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  rmot_pkg::rsp_t rsp,
    output int             mismatch_count,
    output int             awaiting,
    output int             checked_count,
    output int             select_hits,
    output int             places_moved,
    output int             full_refusals,
    output int             peak_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0]        tbl_move  [MAX_MOVES];
    logic signed [15:0] tbl_score [MAX_MOVES];
    logic [1:0]         tbl_flag  [MAX_MOVES];
    logic [7:0]         tbl_depth [MAX_MOVES];
    int n_moves = 0;
    int cur_pos = 0;

    rmot_pkg::rsp_t predicted_rsp[$];
    int n_bad = 0;
    int in_flight = 0;
    int n_checked = 0;
    int n_hits = 0;
    int n_shifted = 0;
    int n_refused = 0;
    int n_peak = 0;

    assign mismatch_count = n_bad;
    assign awaiting = in_flight;
    assign checked_count = n_checked;
    assign select_hits = n_hits;
    assign places_moved = n_shifted;
    assign full_refusals = n_refused;
    assign peak_count = n_peak;

    function automatic rmot_pkg::rsp_t entry_view(input int idx);
        rmot_pkg::rsp_t r;
        r = '0;
        r.found = 1'b1;
        r.position = 8'(idx);
        r.entry_move = tbl_move[idx];
        r.entry_score = tbl_score[idx];
        r.entry_flag = tbl_flag[idx];
        r.entry_depth = tbl_depth[idx];
        return r;
    endfunction

    function automatic rmot_pkg::rsp_t apply_command(input rmot_pkg::cmd_t c);
        rmot_pkg::rsp_t r;
        logic signed [15:0] lo_win;
        logic signed [15:0] hi_win;
        logic [15:0] tm;
        logic signed [15:0] ts;
        logic [1:0] tf;
        logic [7:0] td;
        int p;
        r = '0;
        lo_win = c.alpha_bound;
        hi_win = c.beta_bound;
        case (c.mode)
            rmot_pkg::MODE_CLEAR:
            begin
                n_moves = 0;
                cur_pos = 0;
            end
            rmot_pkg::MODE_APPEND:
            begin
                if (n_moves < MAX_MOVES)
                begin
                    tbl_move[n_moves] = c.move_code;
                    tbl_score[n_moves] = '0;
                    tbl_flag[n_moves] = rmot_pkg::FLAG_NONE;
                    tbl_depth[n_moves] = '0;
                    r = entry_view(n_moves);
                    n_moves++;
                end
                else
                    r.full_error = 1'b1;
            end
            rmot_pkg::MODE_CLEAR_FLAG:
            begin
                for (p = 0; p < n_moves; p++)
                    tbl_flag[p] = rmot_pkg::FLAG_NONE;
            end
            rmot_pkg::MODE_SELECT:
            begin
                for (p = 0; p < n_moves; p++)
                begin
                    if (tbl_depth[p] < c.search_depth ||
                        (tbl_flag[p] == rmot_pkg::FLAG_ALPHA && tbl_score[p] < hi_win) ||
                        (tbl_flag[p] == rmot_pkg::FLAG_BETA && tbl_score[p] > lo_win))
                    begin
                        cur_pos = p;
                        r = entry_view(p);
                        break;
                    end
                end
            end
            rmot_pkg::MODE_UPDATE:
            begin
                if (cur_pos < n_moves)
                begin
                    p = cur_pos;
                    tbl_score[p] = c.new_score;
                    tbl_flag[p] = c.new_flag;
                    tbl_depth[p] = c.search_depth;
                    // Walk forward past lower-scored entries of equal depth.
                    while (p > 0 && tbl_depth[p] == tbl_depth[p-1] &&
                           tbl_score[p] > tbl_score[p-1])
                    begin
                        tm = tbl_move[p-1];
                        ts = tbl_score[p-1];
                        tf = tbl_flag[p-1];
                        td = tbl_depth[p-1];
                        tbl_move[p-1] = tbl_move[p];
                        tbl_score[p-1] = tbl_score[p];
                        tbl_flag[p-1] = tbl_flag[p];
                        tbl_depth[p-1] = tbl_depth[p];
                        tbl_move[p] = tm;
                        tbl_score[p] = ts;
                        tbl_flag[p] = tf;
                        tbl_depth[p] = td;
                        p--;
                        n_shifted++;
                    end
                    cur_pos = p;
                    r = entry_view(p);
                end
            end
            rmot_pkg::MODE_READ:
            begin
                if (int'(c.entry_index) < n_moves)
                    r = entry_view(int'(c.entry_index));
                else
                    r.position = c.entry_index;
            end
            default:
            begin
            end
        endcase
        r.at_front = (cur_pos == 0);
        r.entry_count = 9'(n_moves);
        return r;
    endfunction

    function automatic string show_rsp(input rmot_pkg::rsp_t r);
        return $sformatf({"found=%0d pos=%0d move=%h score=%0d flag=%0d depth=%0d ",
                          "front=%0d count=%0d full=%0d"},
                         r.found, r.position, r.entry_move, r.entry_score, r.entry_flag,
                         r.entry_depth, r.at_front, r.entry_count, r.full_error);
    endfunction

    always @(posedge clk)
    begin
        rmot_pkg::rsp_t want;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                want = apply_command(cmd);
                predicted_rsp.push_back(want);
                if (cmd.mode == rmot_pkg::MODE_SELECT && want.found)
                    n_hits++;
                if (want.full_error)
                    n_refused++;
                if (n_moves > n_peak)
                    n_peak = n_moves;
            end
            if (rsp_valid && !rsp_stall)
            begin
                n_checked++;
                if (predicted_rsp.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("ERROR %0t: result with no command pending: %s",
                                 $realtime, show_rsp(rsp));
                end
                else
                begin
                    want = predicted_rsp.pop_front();
                    if (rsp.found !== want.found || rsp.position !== want.position ||
                        rsp.entry_move !== want.entry_move ||
                        rsp.entry_score !== want.entry_score ||
                        rsp.entry_flag !== want.entry_flag ||
                        rsp.entry_depth !== want.entry_depth ||
                        rsp.at_front !== want.at_front ||
                        rsp.entry_count !== want.entry_count ||
                        rsp.full_error !== want.full_error)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                        begin
                            $display("ERROR %0t: result %0d differs", $realtime, n_checked);
                            $display("  expected %s", show_rsp(want));
                            $display("  actual   %s", show_rsp(rsp));
                        end
                    end
                end
            end
            in_flight = predicted_rsp.size();
        end
    end

endmodule

@@ sim/tb_root_move_ordering_table.sv @@
// Top of the root move ordering table testbench: clock, reset, command
// stimulus, result-side stalls, watchdog and verdict.
// Depends on rmot_pkg, root_move_ordering_table and rmot_checker.
module tb_root_move_ordering_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE = rmot_pkg::MAX_MOVES_DEF;
    localparam int ITEM_GOAL = 650;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int QUIET_LIMIT = 5000;

    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam logic [1:0] FLAG_EXACT = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    rmot_pkg::cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rmot_pkg::rsp_t rsp;

    int mismatch_count;
    int awaiting;
    int checked_count;
    int select_hits;
    int places_moved;
    int full_refusals;
    int peak_count;

    int sent = 0;
    int mode_tally [8];
    bit steady = 1'b0;

    always #5 clk = ~clk;

    root_move_ordering_table #(
        .MAX_MOVES(TABLE_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    rmot_checker #(
        .MAX_MOVES(TABLE_SIZE)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .mismatch_count(mismatch_count),
        .awaiting(awaiting),
        .checked_count(checked_count),
        .select_hits(select_hits),
        .places_moved(places_moved),
        .full_refusals(full_refusals),
        .peak_count(peak_count)
    );

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Scores and window bounds cluster near zero so that equal and adjacent
    // values are common, with the extremes mixed in.
    function automatic logic signed [15:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 16'sh8000;
        if (r < 24)
            return 16'sh7FFF;
        if (r < 65)
            return 16'($urandom_range(0, 12) - 6);
        return 16'($urandom);
    endfunction

    // All fields random; callers overwrite the ones the command uses.
    function automatic rmot_pkg::cmd_t noise_cmd();
        rmot_pkg::cmd_t c;
        c.mode = 3'($urandom);
        c.move_code = 16'($urandom);
        c.alpha_bound = 16'($urandom);
        c.beta_bound = 16'($urandom);
        c.search_depth = 8'($urandom);
        c.new_score = 16'($urandom);
        c.new_flag = 2'($urandom);
        c.entry_index = 8'($urandom);
        return c;
    endfunction

    task automatic send_cmd(input rmot_pkg::cmd_t c);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sent++;
        mode_tally[c.mode]++;
    endtask

    task automatic do_plain(input logic [2:0] mode);
        rmot_pkg::cmd_t c;
        c = noise_cmd();
        c.mode = mode;
        send_cmd(c);
    endtask

    task automatic do_append(input logic [15:0] code);
        rmot_pkg::cmd_t c;
        c = noise_cmd();
        c.mode = rmot_pkg::MODE_APPEND;
        c.move_code = code;
        send_cmd(c);
    endtask

    task automatic do_select(input logic [7:0] want, input logic signed [15:0] lo,
                             input logic signed [15:0] hi);
        rmot_pkg::cmd_t c;
        c = noise_cmd();
        c.mode = rmot_pkg::MODE_SELECT;
        c.search_depth = want;
        c.alpha_bound = lo;
        c.beta_bound = hi;
        send_cmd(c);
    endtask

    task automatic do_update(input logic signed [15:0] score, input logic [1:0] flag,
                             input logic [7:0] depth);
        rmot_pkg::cmd_t c;
        c = noise_cmd();
        c.mode = rmot_pkg::MODE_UPDATE;
        c.new_score = score;
        c.new_flag = flag;
        c.search_depth = depth;
        send_cmd(c);
    endtask

    task automatic do_read(input logic [7:0] idx);
        rmot_pkg::cmd_t c;
        c = noise_cmd();
        c.mode = rmot_pkg::MODE_READ;
        c.entry_index = idx;
        send_cmd(c);
    endtask

    // A search over one position: fill a small table, then deepen round by
    // round, selecting and updating entries as a root search would.
    task automatic search_position(input int size);
        int rounds;
        int base;
        int steps;
        int roll;
        int k;
        int r;
        do_plain(rmot_pkg::MODE_CLEAR);
        for (k = 0; k < size; k++)
            do_append(16'($urandom));
        base = $urandom_range(0, 250);
        rounds = (size > 10) ? 1 : $urandom_range(1, 3);
        for (r = 1; r <= rounds; r++)
        begin
            steps = $urandom_range(1, size + 2);
            for (k = 0; k < steps; k++)
            begin
                do_select(8'(base + r), pick_value(), pick_value());
                roll = $urandom_range(0, 19);
                if (roll < 14)
                    do_update(pick_value(), 2'($urandom), 8'(base + r));
                else if (roll < 16)
                    do_update(pick_value(), 2'($urandom), 8'($urandom));
                else if (roll < 18)
                    do_read(8'($urandom_range(0, size + 1)));
                else if (roll < 19)
                    do_plain(rmot_pkg::MODE_CLEAR_FLAG);
                else
                    do_append(16'($urandom));
            end
        end
    endtask

    // Fill the table completely, push past the end, and scan it whole.
    task automatic fill_table();
        int k;
        do_plain(rmot_pkg::MODE_CLEAR);
        for (k = 0; k < TABLE_SIZE + 2; k++)
            do_append(16'($urandom));
        do_read(8'd255);
        do_read(8'd0);
        do_select(8'd0, 16'sh7FFF, 16'sh8000);
        do_select(8'd1, pick_value(), pick_value());
        do_update(pick_value(), rmot_pkg::FLAG_BETA, 8'd0);
        do_plain(rmot_pkg::MODE_CLEAR_FLAG);
        do_plain(rmot_pkg::MODE_CLEAR);
    endtask

    initial
    begin : stimulus
        bit filled;
        int k;
        int burst;
        filled = 1'b0;
        for (k = 0; k < 8; k++)
            mode_tally[k] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: out-of-range read, update with no current entry,
        // select with nothing to find, flag clear and the spare modes.
        do_read(8'd0);
        do_update(16'sd5, rmot_pkg::FLAG_ALPHA, 8'd3);
        do_select(8'd255, 16'sh8000, 16'sh7FFF);
        do_plain(rmot_pkg::MODE_CLEAR_FLAG);
        do_plain(MODE_SPARE_A);
        do_plain(MODE_SPARE_B);
        do_append(16'hFFFF);
        do_append(16'h0000);
        do_append(16'h8001);
        do_read(8'd2);
        do_read(8'd3);
        do_read(8'd255);
        do_update(16'sh7FFE, rmot_pkg::FLAG_ALPHA, 8'd255);
        do_select(8'd0, 16'sh7FFF, 16'sh8000);
        do_select(8'd0, 16'sh7FFF, 16'sh7FFF);
        do_select(8'd1, 16'sh7FFF, 16'sh8000);
        do_update(16'sh8001, rmot_pkg::FLAG_BETA, 8'd255);
        do_select(8'd0, 16'sh8000, 16'sh8000);
        do_select(8'd1, 16'sh7FFF, 16'sh8000);
        // Equal depth and a higher score: this entry moves one place forward.
        do_update(16'sd100, FLAG_EXACT, 8'd255);
        // The exact-flagged entry must not satisfy the bound tests.
        do_select(8'd0, 16'sh8000, 16'sh8000);
        do_plain(rmot_pkg::MODE_CLEAR_FLAG);
        do_select(8'd0, 16'sh8000, 16'sh7FFF);
        do_read(8'd1);
        do_plain(rmot_pkg::MODE_CLEAR);
        do_read(8'd0);
        do_update(16'sd7, rmot_pkg::FLAG_BETA, 8'd9);

        while (sent < ITEM_GOAL)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if (!filled && sent >= 150)
            begin
                fill_table();
                filled = 1'b1;
            end
            else if ($urandom_range(0, 6) == 0)
            begin
                burst = $urandom_range(1, 6);
                for (k = 0; k < burst; k++)
                    send_cmd(noise_cmd());
            end
            else if ($urandom_range(0, 6) == 0)
                search_position($urandom_range(11, 40));
            else
                search_position($urandom_range(1, 10));
        end
        cmd_valid <= 1'b0;
        steady = 1'b0;

        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display({"summary: %0d commands: clear %0d, append %0d, flag clear %0d, ",
                  "select %0d, update %0d, read %0d, spare %0d"},
                 sent, mode_tally[rmot_pkg::MODE_CLEAR], mode_tally[rmot_pkg::MODE_APPEND],
                 mode_tally[rmot_pkg::MODE_CLEAR_FLAG], mode_tally[rmot_pkg::MODE_SELECT],
                 mode_tally[rmot_pkg::MODE_UPDATE], mode_tally[rmot_pkg::MODE_READ],
                 mode_tally[MODE_SPARE_A] + mode_tally[MODE_SPARE_B]);
        $display({"summary: %0d results checked, %0d select hits, %0d places moved, ",
                  "%0d refused appends, peak size %0d"},
                 checked_count, select_hits, places_moved, full_refusals, peak_count);
        if (mismatch_count == 0 && awaiting == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off while commands keep
    // coming so that the block backs up into its input.
    initial
    begin : result_side
        int run;
        int taken;
        bit squeezed;
        taken = 0;
        squeezed = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!squeezed && taken >= 150)
            begin
                squeezed = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            run = idle_len();
            if (run > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (run) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
            repeat (run)
            begin
                @(posedge clk);
                if (rsp_valid && !rsp_stall)
                    taken++;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no item moved on either channel for %0d cycles", QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule
